// ===== hw/rtl/hps_pkg.sv =====
// Shared types, constants and pulse-table functions of the haptic pattern sequencer.
package hps_pkg;

  // Guidance range and pattern length
  localparam int unsigned MAX_DISTANCE  = 2560;
  localparam int unsigned PATTERN_STEPS = 2;

  // Pulse table
  localparam logic [7:0] PULSE_LEVEL    = 8'd210;
  localparam int unsigned TAB_BITS      = 9;
  localparam logic [TAB_BITS-1:0] ON_MS        = 9'd45;
  localparam logic [TAB_BITS-1:0] OFF_FIRST_MS = 9'd120;
  localparam logic [TAB_BITS-1:0] OFF_LAST_MS  = 9'd260;

  // Configuration register map
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 16;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COOLDOWN  = 1'd1;
  localparam logic [14:0] RESET_THRESHOLD = 15'd13;
  localparam logic [15:0] RESET_COOLDOWN  = 16'd500;

  // Input function codes
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_PACKET = 1'b1;

  // Guidance level = floor((MAX - m) * 255 / MAX) as a reciprocal multiply.
  // With a round-up reciprocal and shift = N + ceil(log2 MAX), the quotient
  // of any N-bit dividend is exact.
  localparam int unsigned DIST_BITS   = $clog2(MAX_DISTANCE + 1);
  localparam int unsigned PROD_BITS   = DIST_BITS + 8;
  localparam int unsigned RECIP_SHIFT = PROD_BITS + $clog2(MAX_DISTANCE);
  localparam int unsigned RECIP_BITS  = PROD_BITS + 1;
  localparam logic [RECIP_BITS-1:0] RECIP = RECIP_BITS'(
      ((64'd1 << RECIP_SHIFT) + 64'(MAX_DISTANCE) - 64'd1) / 64'(MAX_DISTANCE));

  typedef struct packed {
    logic [14:0] target_threshold;
    logic [15:0] cooldown_ms;
  } hps_cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [31:0] step_deadline;
    logic [31:0] last_start_ms;
    logic        in_pattern;
    logic [1:0]  step_index;
    logic        phase_on;
    logic [7:0]  drive_level;
  } hps_state_t;

  typedef struct packed {
    logic [7:0] motor_level;
    logic       level_written;
    logic       pattern_active;
    logic       pattern_started;
  } hps_result_t;

  function automatic logic [TAB_BITS-1:0] on_ms(input logic [1:0] idx);
    logic [1:0] unused_idx;
    unused_idx = idx;
    return ON_MS;
  endfunction

  function automatic logic [TAB_BITS-1:0] off_ms(input logic [1:0] idx);
    return (idx == 2'd0) ? OFF_FIRST_MS : OFF_LAST_MS;
  endfunction

endpackage

// ===== hw/rtl/hps_cfg_regs.sv =====
// Configuration register file: pattern threshold and retrigger cooldown.
module hps_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hps_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [hps_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output hps_pkg::hps_cfg_t                cfg_o
);

  hps_pkg::hps_cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        hps_pkg::REG_THRESHOLD: cfg_d.target_threshold = cfg_data_i[14:0];
        hps_pkg::REG_COOLDOWN:  cfg_d.cooldown_ms      = cfg_data_i[15:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_threshold <= hps_pkg::RESET_THRESHOLD;
      cfg_q.cooldown_ms      <= hps_pkg::RESET_COOLDOWN;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/hps_step.sv =====
// Next-state and result logic for one tick or distance packet.
module hps_step (
  input  hps_pkg::hps_cfg_t    cfg_i,
  input  hps_pkg::hps_state_t  state_i,
  input  logic                 func_i,
  input  logic signed [15:0]   distance_i,
  output hps_pkg::hps_state_t  state_o,
  output hps_pkg::hps_result_t result_o
);

  localparam int unsigned MulBits = hps_pkg::PROD_BITS + hps_pkg::RECIP_BITS;

  hps_pkg::hps_state_t svc;
  logic [31:0] now_ms;
  logic [31:0] due_diff;
  logic [31:0] since_start;
  logic [1:0]  idx_next;
  logic        svc_written;
  logic        is_packet;
  logic        dist_neg;
  logic [14:0] dist_mag;
  logic        can_start;
  logic [14:0] dist_sat;
  logic [hps_pkg::DIST_BITS-1:0] dist_left;
  logic [hps_pkg::PROD_BITS-1:0] scaled;
  logic [MulBits-1:0]            quot_full;
  logic [7:0]                    guide_level;

  assign is_packet = (func_i == hps_pkg::FUNC_PACKET);
  assign now_ms    = is_packet ? state_i.now_ms : state_i.now_ms + 32'd1;
  assign due_diff  = now_ms - state_i.step_deadline;
  assign idx_next  = state_i.step_index + 2'd1;

  // Service the running pattern at the current millisecond
  always_comb begin
    svc         = state_i;
    svc.now_ms  = now_ms;
    svc_written = 1'b0;
    if (state_i.in_pattern && !due_diff[31]) begin
      svc_written = 1'b1;
      if (state_i.phase_on) begin
        svc.drive_level   = 8'd0;
        svc.phase_on      = 1'b0;
        svc.step_deadline = now_ms + 32'(hps_pkg::off_ms(state_i.step_index));
      end else begin
        svc.step_index = idx_next;
        if (idx_next >= 2'(hps_pkg::PATTERN_STEPS)) begin
          svc.drive_level = 8'd0;
          svc.in_pattern  = 1'b0;
        end else begin
          svc.drive_level   = hps_pkg::PULSE_LEVEL;
          svc.phase_on      = 1'b1;
          svc.step_deadline = now_ms + 32'(hps_pkg::on_ms(idx_next));
        end
      end
    end
  end

  // Guidance level by reciprocal multiply
  assign dist_neg    = distance_i[15];
  assign dist_mag    = distance_i[14:0];
  assign dist_sat    = (dist_mag > 15'(hps_pkg::MAX_DISTANCE)) ?
                       15'(hps_pkg::MAX_DISTANCE) : dist_mag;
  assign dist_left   = hps_pkg::DIST_BITS'(15'(hps_pkg::MAX_DISTANCE) - dist_sat);
  assign scaled      = {dist_left, 8'd0} - hps_pkg::PROD_BITS'(dist_left);
  assign quot_full   = MulBits'(scaled) * MulBits'(hps_pkg::RECIP);
  assign guide_level = quot_full[hps_pkg::RECIP_SHIFT +: 8];

  assign since_start = now_ms - state_i.last_start_ms;
  assign can_start   = !dist_neg && (dist_mag <= cfg_i.target_threshold) &&
                       !svc.in_pattern && (since_start > {16'd0, cfg_i.cooldown_ms});

  always_comb begin
    state_o                  = svc;
    result_o.level_written   = svc_written;
    result_o.pattern_started = 1'b0;
    if (is_packet) begin
      if (dist_neg) begin
        if (!svc.in_pattern) begin
          state_o.drive_level    = 8'd0;
          result_o.level_written = 1'b1;
        end
      end else if (can_start) begin
        state_o.last_start_ms    = now_ms;
        state_o.in_pattern       = 1'b1;
        state_o.step_index       = 2'd0;
        state_o.phase_on         = 1'b1;
        state_o.drive_level      = hps_pkg::PULSE_LEVEL;
        state_o.step_deadline    = now_ms + 32'(hps_pkg::on_ms(2'd0));
        result_o.level_written   = 1'b1;
        result_o.pattern_started = 1'b1;
      end else if (!svc.in_pattern) begin
        state_o.drive_level    = guide_level;
        result_o.level_written = 1'b1;
      end
    end
    result_o.motor_level    = state_o.drive_level;
    result_o.pattern_active = state_o.in_pattern;
  end

endmodule

// ===== hw/rtl/haptic_pattern_sequencer.sv =====
// Haptic pattern sequencer top level: input register, step logic, state and result register.
//
// Usage:
//   Input beats (in_valid_i / in_stall_o) carry func_i and distance_i. A func_i of
//   zero is a one millisecond tick, one is a distance packet (negative = no tile).
//   Each input beat produces exactly one output beat (out_valid_o / out_stall_i)
//   with the motor level after the beat, whether it wrote the level, whether the
//   pulse pattern plays and whether this beat started it.
//   A beat passes the input register, then the step logic into the result register.
//   Throughput is one beat per cycle while the receiver does not stall, set by the single
//   pass through the step logic, which also updates the state.
//   When the receiver stalls, the result register holds its beat; the input
//   register still takes one more beat, and in_stall_o rises only once both are
//   full and the receiver keeps stalling.
//   The config port (cfg_valid_i / cfg_ready_o) is always ready; index 0 writes
//   the 15-bit pattern threshold, index 1 the 16-bit cooldown in milliseconds.
//   Write it only while no beat is in flight.
//   Reset clears the millisecond counter, deadlines and pattern state (guidance
//   mode, motor off), loads threshold 13 and cooldown 500, and empties both
//   registers.
module haptic_pattern_sequencer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hps_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [hps_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  // input beats
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             func_i,
  input  logic signed [15:0]               distance_i,
  // output beats
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       motor_level_o,
  output logic                             level_written_o,
  output logic                             pattern_active_o,
  output logic                             pattern_started_o
);

  hps_pkg::hps_cfg_t    cfg;
  hps_pkg::hps_state_t  state_q, state_next;
  hps_pkg::hps_result_t res_q, res_next;

  logic                 in_valid_q, in_valid_d;
  logic                 func_q;
  logic signed [15:0]   distance_q;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;
  logic                 fire;
  logic                 accept;

  hps_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Result register is free when empty or being taken this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  hps_step u_step (
    .cfg_i      (cfg),
    .state_i    (state_q),
    .func_i     (func_q),
    .distance_i (distance_q),
    .state_o    (state_next),
    .result_o   (res_next)
  );

  // Control and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (fire) begin
        state_q <= state_next;
      end
    end
  end

  // Payload: capture the input beat on accept and the result on fire, hold otherwise
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q     <= func_i;
      distance_q <= distance_i;
    end
    if (fire) begin
      res_q <= res_next;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign motor_level_o     = res_q.motor_level;
  assign level_written_o   = res_q.level_written;
  assign pattern_active_o  = res_q.pattern_active;
  assign pattern_started_o = res_q.pattern_started;

  // A start always writes the pulse level and leaves the pattern playing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && pattern_started_o |->
      pattern_active_o && level_written_o && motor_level_o == hps_pkg::PULSE_LEVEL)
    else $error("pattern start beat without active pulse output");

  // Outside a pattern the on phase is never left set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.in_pattern |-> !state_q.phase_on)
    else $error("phase_on set in guidance mode");

  // Step index stays within the pulse table while playing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.in_pattern |-> state_q.step_index < 2'(hps_pkg::PATTERN_STEPS))
    else $error("step index beyond pattern length");

  // Backpressure only when both registers are full and the receiver stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

endmodule

// ===== bench/haptic_pattern_sequencer_tb.sv =====
// Self-checking testbench for the haptic pattern sequencer with a built-in behavioral predictor.
`timescale 1ns / 1ps

module haptic_pattern_sequencer_tb;

  // Two register stages between an input beat and its result.
  localparam int unsigned LATENCY     = 2;
  // Worst case is about a thousand beats, each waiting out a long send gap and a
  // long receiver stall; take that several times over.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PHASE_BEATS = 170;

  // Off time of each pulse step; the last step repeats for any longer pattern.
  localparam logic [hps_pkg::TAB_BITS-1:0] OFF_TIME [4] = '{hps_pkg::OFF_FIRST_MS,
                                                            hps_pkg::OFF_LAST_MS,
                                                            hps_pkg::OFF_LAST_MS,
                                                            hps_pkg::OFF_LAST_MS};

  typedef struct packed {
    logic               func;
    logic signed [15:0] distance;
  } stim_beat_t;

  logic clk_i;
  logic rst_ni = 1'b0;

  // Block inputs, all known from time zero
  logic                              cfg_valid = 1'b0;
  logic [hps_pkg::CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [hps_pkg::CFG_DATA_BITS-1:0] cfg_data  = '0;
  logic                              in_valid  = 1'b0;
  logic                              in_func   = hps_pkg::FUNC_TICK;
  logic signed [15:0]                in_dist   = '0;
  logic                              out_stall = 1'b0;

  // Block outputs
  logic       cfg_ready_o;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] motor_level_o;
  logic       level_written_o;
  logic       pattern_active_o;
  logic       pattern_started_o;

  // Predictor state, mirrors the sequencer after every accepted beat
  logic [14:0] start_threshold = hps_pkg::RESET_THRESHOLD;
  logic [15:0] cooldown        = hps_pkg::RESET_COOLDOWN;
  logic [31:0] ms_count        = '0;
  logic [31:0] next_deadline   = '0;
  logic [31:0] last_start      = '0;
  logic        pulsing         = 1'b0;
  logic [1:0]  step_no         = '0;
  logic        pulse_on        = 1'b0;
  logic [7:0]  level           = '0;

  stim_beat_t           pending_beats_q [$];
  hps_pkg::hps_result_t predicted_q     [$];

  int unsigned mismatch_count = 0;
  int unsigned in_gap         = 0;
  int unsigned in_calm        = 0;
  int unsigned stall_left     = 0;
  int unsigned out_calm       = 0;
  int unsigned cycles         = 0;

  haptic_pattern_sequencer i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall_o),
    .func_i            (in_func),
    .distance_i        (in_dist),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall),
    .motor_level_o     (motor_level_o),
    .level_written_o   (level_written_o),
    .pattern_active_o  (pattern_active_o),
    .pattern_started_o (pattern_started_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Advance the pulse table if the current step deadline has been reached.
  // The deadline counts as reached once the wrap-around difference is not negative.
  function automatic logic service_pulse_steps();
    logic [31:0] slack;
    if (!pulsing) return 1'b0;
    slack = ms_count - next_deadline;
    if (slack[31]) return 1'b0;
    if (pulse_on) begin
      // End of an on phase: motor off, hold for this step's off time
      level         = '0;
      pulse_on      = 1'b0;
      next_deadline = ms_count + 32'(OFF_TIME[step_no]);
    end else begin
      step_no = step_no + 2'd1;
      if (step_no >= 2'(hps_pkg::PATTERN_STEPS)) begin
        // Table exhausted: drop back to guidance mode
        level   = '0;
        pulsing = 1'b0;
      end else begin
        level         = hps_pkg::PULSE_LEVEL;
        pulse_on      = 1'b1;
        next_deadline = ms_count + 32'(hps_pkg::ON_MS);
      end
    end
    return 1'b1;
  endfunction

  // Work out the result of one accepted beat and update the predictor state.
  function automatic hps_pkg::hps_result_t predict_beat(input logic func,
                                                        input logic signed [15:0] distance);
    hps_pkg::hps_result_t res;
    logic        wrote;
    logic        started;
    logic [14:0] near;
    logic [31:0] lag;
    int unsigned span;
    started = 1'b0;
    if (func == hps_pkg::FUNC_TICK) ms_count = ms_count + 32'd1;
    // Packets service the table too, at the unchanged millisecond count
    wrote = service_pulse_steps();
    if (func == hps_pkg::FUNC_PACKET) begin
      near = distance[14:0];
      lag  = ms_count - last_start;
      if (distance[15]) begin
        // No tile: silence the motor, but never cut into a playing pattern
        if (!pulsing) begin
          level = '0;
          wrote = 1'b1;
        end
      end else if (near <= start_threshold && !pulsing && lag > 32'(cooldown)) begin
        last_start    = ms_count;
        pulsing       = 1'b1;
        step_no       = '0;
        pulse_on      = 1'b1;
        level         = hps_pkg::PULSE_LEVEL;
        next_deadline = ms_count + 32'(hps_pkg::ON_MS);
        wrote         = 1'b1;
        started       = 1'b1;
      end else if (!pulsing) begin
        // Guidance: linear ramp, saturating beyond the range
        span  = (near > hps_pkg::MAX_DISTANCE) ? hps_pkg::MAX_DISTANCE : int'(near);
        level = 8'(((hps_pkg::MAX_DISTANCE - span) * 255) / hps_pkg::MAX_DISTANCE);
        wrote = 1'b1;
      end
    end
    res.motor_level     = level;
    res.level_written   = wrote;
    res.pattern_active  = pulsing;
    res.pattern_started = started;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Helpers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // Idle length for either side: mostly none or short, a few long, and now and
  // then a calm stretch with no idling at all.
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 63) == 0) begin
      calm = $urandom_range(20, 120);
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_beat(input logic func, input logic signed [15:0] distance);
    pending_beats_q.push_back(stim_beat_t'{func: func, distance: distance});
  endtask

  // Fill one phase with runs of ticks and packets aimed at the current threshold,
  // plus some noise. Tick runs keep the pulse table moving through its steps.
  task automatic queue_random_phase(input int unsigned count, input logic [14:0] thr);
    int unsigned made;
    int unsigned run;
    int unsigned roll;
    logic signed [15:0] distance;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 30) begin
        run = ($urandom_range(0, 24) == 0) ? $urandom_range(100, 250) : $urandom_range(1, 20);
        repeat (run) queue_beat(hps_pkg::FUNC_TICK, 16'($urandom));
        made += run;
      end else if (roll < 90) begin
        if (roll < 45) begin
          // Near: threshold edges and anything below
          case ($urandom_range(0, 3))
            0:       distance = '0;
            1:       distance = {1'b0, thr};
            2:       distance = (thr == 15'h7fff) ? {1'b0, thr} : {1'b0, thr + 15'd1};
            default: distance = 16'($urandom_range(0, thr));
          endcase
        end else if (roll < 75) begin
          distance = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 32767))
                                                 : 16'($urandom_range(0, hps_pkg::MAX_DISTANCE));
        end else begin
          distance = {1'b1, 15'($urandom)};
        end
        queue_beat(hps_pkg::FUNC_PACKET, distance);
        made++;
      end else begin
        queue_beat(1'($urandom), 16'($urandom));
        made++;
      end
    end
  endtask

  // Wait until every queued beat went in and every result came out, then let
  // the pipeline settle. Look between edges, once all updates have landed.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_beats_q.size() != 0 || in_valid || predicted_q.size() != 0);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // Write one register; only called while the block is idle.
  task automatic write_reg(input logic [hps_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [15:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    // The write lands at this edge: mirror it in the predictor
    if (idx == hps_pkg::REG_THRESHOLD) begin
      start_threshold = data[14:0];
    end else begin
      cooldown = data;
    end
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: feed pending beats, idle at random between them
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    stim_beat_t nxt;
    // Hold the beat while stalled; otherwise advance
    if (rst_ni && (!in_valid || !in_stall_o)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_beats_q.size() > 0) begin
        nxt = pending_beats_q.pop_front();
        in_valid <= 1'b1;
        in_func  <= nxt.func;
        in_dist  <= nxt.distance;
        in_gap = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on every accepted input beat, check every result beat
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hps_pkg::hps_result_t want;
    if (rst_ni) begin
      // A result never comes out in the cycle its beat goes in, so predict first
      if (in_valid && !in_stall_o) begin
        predicted_q.push_back(predict_beat(in_func, in_dist));
      end
      if (out_valid_o && !out_stall) begin
        if (predicted_q.size() == 0) begin
          report_mismatch($sformatf("result beat with none pending (level %0d)", motor_level_o));
        end else begin
          want = predicted_q.pop_front();
          if (motor_level_o !== want.motor_level)
            report_mismatch($sformatf("motor_level got %0d want %0d",
                                      motor_level_o, want.motor_level));
          if (level_written_o !== want.level_written)
            report_mismatch($sformatf("level_written got %0b want %0b",
                                      level_written_o, want.level_written));
          if (pattern_active_o !== want.pattern_active)
            report_mismatch($sformatf("pattern_active got %0b want %0b",
                                      pattern_active_o, want.pattern_active));
          if (pattern_started_o !== want.pattern_started)
            report_mismatch($sformatf("pattern_started got %0b want %0b",
                                      pattern_started_o, want.pattern_started));
        end
      end
    end
    // Receiver side: stall in bursts of random length
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = pick_gap(out_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // Timeout
  // ---------------------------------------------------------------------------
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings, cooldown not yet passed: everything is guidance
    queue_beat(hps_pkg::FUNC_PACKET, 16'sh8000);   // most negative: no tile
    queue_beat(hps_pkg::FUNC_PACKET, -16'sd1);
    queue_beat(hps_pkg::FUNC_PACKET, 16'sd0);      // near, but the boot cooldown holds
    queue_beat(hps_pkg::FUNC_PACKET, 16'sd13);     // exactly at threshold
    queue_beat(hps_pkg::FUNC_PACKET, 16'sd14);
    queue_beat(hps_pkg::FUNC_PACKET, 16'sh7fff);   // saturates to zero drive
    queue_beat(hps_pkg::FUNC_PACKET, 16'(hps_pkg::MAX_DISTANCE));
    queue_beat(hps_pkg::FUNC_PACKET, 16'(hps_pkg::MAX_DISTANCE - 1));
    queue_beat(hps_pkg::FUNC_PACKET, 16'(hps_pkg::MAX_DISTANCE / 2));
    queue_beat(hps_pkg::FUNC_TICK, 16'sh7fff);     // distance ignored on ticks
    queue_beat(hps_pkg::FUNC_TICK, 16'sh8000);
    wait_idle();

    // Widest threshold, no cooldown: start the pattern, then poke it
    write_reg(hps_pkg::REG_THRESHOLD, 16'h7fff);
    write_reg(hps_pkg::REG_COOLDOWN, 16'h0000);
    queue_beat(hps_pkg::FUNC_PACKET, 16'sd0);      // starts the pattern
    queue_beat(hps_pkg::FUNC_PACKET, -16'sd5);     // no tile while playing: drive untouched
    queue_beat(hps_pkg::FUNC_PACKET, 16'sd30000);  // far while playing: drive untouched
    queue_beat(hps_pkg::FUNC_PACKET, 16'sd3);      // near while playing: no restart
    repeat (3) queue_beat(hps_pkg::FUNC_TICK, 16'($urandom));
    wait_idle();

    // Random phases across several settings; bit 15 of the threshold write is dropped
    write_reg(hps_pkg::REG_THRESHOLD, 16'h8000);
    queue_random_phase(PHASE_BEATS, start_threshold);
    wait_idle();

    write_reg(hps_pkg::REG_THRESHOLD, 16'd300);
    write_reg(hps_pkg::REG_COOLDOWN, 16'd50);
    queue_random_phase(PHASE_BEATS, start_threshold);
    wait_idle();

    // Longest cooldown: near packets fall back to guidance
    write_reg(hps_pkg::REG_THRESHOLD, 16'h7fff);
    write_reg(hps_pkg::REG_COOLDOWN, 16'hffff);
    queue_random_phase(PHASE_BEATS, start_threshold);
    wait_idle();

    write_reg(hps_pkg::REG_THRESHOLD, 16'd2000);
    write_reg(hps_pkg::REG_COOLDOWN, 16'd180);
    queue_random_phase(PHASE_BEATS, start_threshold);
    wait_idle();

    write_reg(hps_pkg::REG_THRESHOLD, 16'($urandom_range(0, 4000)));
    write_reg(hps_pkg::REG_COOLDOWN, 16'($urandom_range(0, 600)));
    queue_random_phase(PHASE_BEATS, start_threshold);
    wait_idle();

    // Anything still pending never arrived
    foreach (predicted_q[i])
      report_mismatch($sformatf("result beat never arrived (level %0d)",
                                predicted_q[i].motor_level));
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
